[sv/rud_pkg.sv]
// ----------------------------------------------------------------------------
// rud_pkg: shared types and helpers for the radial undistortion point unit
// Register indexes, divider stage types, saturation and one divider step.
// ----------------------------------------------------------------------------
package rud_pkg;

	localparam int QuoBits = 24;  // quotient bits produced by the divider
	localparam int DenBits = 40;  // unsigned denominator width (Q.20)

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_INV_FOCAL_X = 3'd0,
		CFG_INV_FOCAL_Y = 3'd1,
		CFG_CENTRE_X    = 3'd2,
		CFG_CENTRE_Y    = 3'd3,
		CFG_RADIAL_K1   = 3'd4,
		CFG_RADIAL_K2   = 3'd5
	} cfg_idx_t;

	// one coordinate inside the divider
	typedef struct packed {
		logic [DenBits-1:0] rem;  // partial remainder, below den while ovf is clear
		logic [23:0]        mag;  // |x|, numerator is mag * 2^20
		logic [QuoBits-1:0] quo;
		logic               neg;
		logic               ovf;  // quotient would not fit in QuoBits
	} div_lane_t;

	// one divider pipeline stage
	typedef struct packed {
		div_lane_t          lx;
		div_lane_t          ly;
		logic [DenBits-1:0] den;
		logic               bad;
		logic               last;
	} div_stage_t;

	// clamp a 34-bit signed value to signed Q4.20
	function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
		logic signed [23:0] r;
		if (v > 34'sd8388607)       r = 24'sh7FFFFF;
		else if (v < -34'sd8388608) r = 24'sh800000;
		else                        r = v[23:0];
		return r;
	endfunction

	// one restoring step, quotient bit b
	function automatic div_lane_t div_step(input div_lane_t a,
			input logic [DenBits-1:0] den, input logic [4:0] b);
		div_lane_t    r;
		logic [DenBits:0] t;
		logic         nb;
		r  = a;
		nb = 1'b0;
		if (b >= 5'd20) nb = a.mag[b - 5'd20];
		t = {a.rem, nb};
		if (t >= {1'b0, den}) begin
			r.rem    = DenBits'(t - {1'b0, den});
			r.quo[b] = 1'b1;
		end else begin
			r.rem = t[DenBits-1:0];
		end
		return r;
	endfunction

	// final signed result of a lane with saturation
	function automatic logic [23:0] lane_result(input div_lane_t a);
		logic [23:0] r;
		if (a.neg) begin
			if (a.ovf || a.quo > 24'd8388608) r = 24'h800000;
			else                              r = 24'(-a.quo);
		end else begin
			if (a.ovf || a.quo > 24'd8388607) r = 24'h7FFFFF;
			else                              r = a.quo;
		end
		return r;
	endfunction

endpackage

[sv/radial_undistort_normalise_point_unit.sv]
// ----------------------------------------------------------------------------
// radial_undistort_normalise_point_unit
// Normalizes a pixel point and removes k1/k2 radial distortion by division.
// ----------------------------------------------------------------------------
// Path: stages s1 to s9, the divider entry register, the divider steps, then the output register.
// Throughput: one point per cycle while the output is not stalled; the
// 24-stage restoring divider takes one quotient bit per stage, two lanes (x and y) side by side.
// A stalled output freezes the whole pipeline and stalls the input.
// Reset (arst_n low, async) clears all valid bits and loads register defaults.
module radial_undistort_normalise_point_unit
	import rud_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [24:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        pixel_x,
	input  logic [15:0]        pixel_y,
	input  logic               last_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] norm_x,
	output logic signed [23:0] norm_y,
	output logic               bad_denominator,
	output logic               last_out
);

	// configuration registers
	logic [24:0]        inv_x_q, inv_y_q;
	logic [15:0]        cen_x_q, cen_y_q;
	logic signed [23:0] k1_q, k2_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_x_q <= 25'd16384;
			inv_y_q <= 25'd16384;
			cen_x_q <= 16'd10240;
			cen_y_q <= 16'd7680;
			k1_q    <= '0;
			k2_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INV_FOCAL_X: inv_x_q <= cfg_data;
				CFG_INV_FOCAL_Y: inv_y_q <= cfg_data;
				CFG_CENTRE_X:    cen_x_q <= cfg_data[15:0];
				CFG_CENTRE_Y:    cen_y_q <= cfg_data[15:0];
				CFG_RADIAL_K1:   k1_q    <= cfg_data[23:0];
				CFG_RADIAL_K2:   k2_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless a result beat is held
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic l_s1, l_s2, l_s3, l_s4, l_s5, l_s6, l_s7, l_s8, l_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8};
		end
	end

	// payload pipeline
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [41:0] px_s2, py_s2;
	logic signed [23:0] x_s3, y_s3, x_s4, y_s4, x_s5, y_s5, x_s6, y_s6;
	logic signed [23:0] x_s7, y_s7, x_s8, y_s8, x_s9, y_s9;
	logic [46:0]        xx_s4, yy_s4;
	logic [27:0]        r2_s5;
	logic [55:0]        r2r2_s6;
	logic signed [52:0] k1r2_s6, k1r2_s7, k1r2_s8;
	logic signed [42:0] k2h_s7, k2l_s7;
	logic signed [61:0] k2sum_s8;
	logic [DenBits-1:0] den_s9;
	logic               bad_s9;

	logic signed [33:0] rx, ry;
	logic signed [47:0] sqx, sqy;
	logic signed [61:0] den40;

	assign rx    = 34'((px_s2 + 42'sd128) >>> 8);
	assign ry    = 34'((py_s2 + 42'sd128) >>> 8);
	assign sqx   = 48'(x_s3) * 48'(x_s3);
	assign sqy   = 48'(y_s3) * 48'(y_s3);
	assign den40 = (62'sd1 <<< 40) + 62'(k1r2_s8) + k2sum_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: offset from principal point
			dx_s1 <= $signed({1'b0, pixel_x}) - $signed({1'b0, cen_x_q});
			dy_s1 <= $signed({1'b0, pixel_y}) - $signed({1'b0, cen_y_q});
			l_s1  <= last_in;
			// s2: scale by reciprocal focal length
			px_s2 <= 42'(dx_s1) * 42'($signed({1'b0, inv_x_q}));
			py_s2 <= 42'(dy_s1) * 42'($signed({1'b0, inv_y_q}));
			l_s2  <= l_s1;
			// s3: round to Q.20 and clamp
			x_s3 <= sat24(rx);
			y_s3 <= sat24(ry);
			l_s3 <= l_s2;
			// s4: squares
			xx_s4 <= 47'(sqx);
			yy_s4 <= 47'(sqy);
			x_s4  <= x_s3;
			y_s4  <= y_s3;
			l_s4  <= l_s3;
			// s5: r2
			r2_s5 <= 28'(({1'b0, xx_s4} + {1'b0, yy_s4}) >> 20);
			x_s5  <= x_s4;
			y_s5  <= y_s4;
			l_s5  <= l_s4;
			// s6: r2 squared, k1 term
			r2r2_s6 <= 56'(r2_s5) * 56'(r2_s5);
			k1r2_s6 <= 53'(k1_q) * 53'($signed({1'b0, r2_s5}));
			x_s6    <= x_s5;
			y_s6    <= y_s5;
			l_s6    <= l_s5;
			// s7: k2 term in two 18-bit halves of r2sq
			k2h_s7  <= 43'(k2_q) * 43'($signed({1'b0, r2r2_s6[55:38]}));
			k2l_s7  <= 43'(k2_q) * 43'($signed({1'b0, r2r2_s6[37:20]}));
			k1r2_s7 <= k1r2_s6;
			x_s7    <= x_s6;
			y_s7    <= y_s6;
			l_s7    <= l_s6;
			// s8: merge k2 halves
			k2sum_s8 <= (62'(k2h_s7) <<< 18) + 62'(k2l_s7);
			k1r2_s8  <= k1r2_s7;
			x_s8     <= x_s7;
			y_s8     <= y_s7;
			l_s8     <= l_s7;
			// s9: denominator at Q.20
			den_s9 <= den40[DenBits+19:20];
			bad_s9 <= den40[61] || (den40[61:20] == 42'd0);
			x_s9   <= x_s8;
			y_s9   <= y_s8;
			l_s9   <= l_s8;
		end
	end

	// divider entry
	function automatic div_lane_t lane_init(input logic signed [23:0] x,
			input logic [DenBits-1:0] den);
		div_lane_t r;
		r.mag = x[23] ? 24'(-x) : x;
		r.neg = x[23];
		r.rem = DenBits'(r.mag[23:4]);
		r.ovf = (DenBits'(r.mag[23:4]) >= den);
		r.quo = '0;
		return r;
	endfunction

	div_stage_t div_s [0:QuoBits];
	logic       div_v_s [0:QuoBits];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s[0] <= 1'b0;
		end else if (en) begin
			div_v_s[0] <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].lx   <= lane_init(x_s9, den_s9);
			div_s[0].ly   <= lane_init(y_s9, den_s9);
			div_s[0].den  <= den_s9;
			div_s[0].bad  <= bad_s9;
			div_s[0].last <= l_s9;
		end
	end

	// one quotient bit per stage, MSB first
	for (genvar j = 0; j < QuoBits; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j+1] <= 1'b0;
			end else if (en) begin
				div_v_s[j+1] <= div_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j+1].lx   <= div_step(div_s[j].lx, div_s[j].den, 5'(QuoBits-1-j));
				div_s[j+1].ly   <= div_step(div_s[j].ly, div_s[j].den, 5'(QuoBits-1-j));
				div_s[j+1].den  <= div_s[j].den;
				div_s[j+1].bad  <= div_s[j].bad;
				div_s[j+1].last <= div_s[j].last;
			end
		end
	end

	// output register
	logic              out_v_q;
	logic [23:0]       nx_q, ny_q;
	logic              bad_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= div_v_s[QuoBits];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_q   <= div_s[QuoBits].bad ? '0 : lane_result(div_s[QuoBits].lx);
			ny_q   <= div_s[QuoBits].bad ? '0 : lane_result(div_s[QuoBits].ly);
			bad_q  <= div_s[QuoBits].bad;
			last_q <= div_s[QuoBits].last;
		end
	end

	assign out_valid       = out_v_q;
	assign norm_x          = nx_q;
	assign norm_y          = ny_q;
	assign bad_denominator = bad_q;
	assign last_out        = last_q;

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_denominator |-> norm_x == 24'sd0 && norm_y == 24'sd0)
		else $error("bad denominator beat with nonzero result");

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow held output");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(div_v_s[QuoBits]) && $stable(v_s9))
		else $error("pipeline moved while stalled");

	a_div_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && div_v_s[QuoBits] |=> out_valid)
		else $error("divider beat lost before output");
`endif

endmodule
